// ===== hdl/best_fit_segment_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Best-fit segment allocator assertion macros
// Shared assertion wrappers. In synthesis they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define BFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define BFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/bfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit segment allocator package
// Default parameters, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package bfsa_pkg;

	localparam int MAX_SEGMENTS_DEF      = 16;
	localparam int HEADER_BYTES_DEF      = 32;
	localparam int POOL_HEADER_BYTES_DEF = 12;
	localparam int ADDR_BITS_DEF         = 16;

	localparam logic [15:0] HEAP_SIZE_RESET = 16'd4096;

	typedef enum logic [1:0] {
		ST_SPLIT = 2'd0,
		ST_WHOLE = 2'd1,
		ST_NOFIT = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // capture request, restart the scan
		logic scan_rd;      // read the next table entry for the fit search
		logic commit_best;  // mark the chosen segment busy
		logic shift_rd;     // read one entry of the shift pass
		logic insert;       // write the split-off free segment
		logic emit;         // present a result beat
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic found;
		logic split;
		logic shift_more;
	} dp_stat_t;

endpackage

// ===== hdl/bfsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bfsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/bfsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit segment allocator controller
// Sequences scan, commit, shift and insert phases of one request.
// ----------------------------------------------------------------------------
module bfsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output bfsa_pkg::ctrl_cmd_t  cmd,
	input  bfsa_pkg::dp_stat_t   stat
);

	import bfsa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_SCAN      = 6'b000010,
		S_SCAN_WAIT = 6'b000100,
		S_DECIDE    = 6'b001000,
		S_SHIFT     = 6'b010000,
		S_INSERT    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.found) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end else if (stat.split) begin
					cmd.commit_best = 1'b1;
					state_d         = S_SHIFT;
				end else begin
					cmd.commit_best = 1'b1;
					cmd.emit        = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_SHIFT: begin
				// The cycle after the last read still writes the final moved entry.
				if (stat.shift_more) begin
					cmd.shift_rd = 1'b1;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				cmd.emit   = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/bfsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit segment allocator datapath
// Segment table memory, best-fit search registers, split arithmetic, result.
// ----------------------------------------------------------------------------
`include "best_fit_segment_allocator_macros.svh"

module bfsa_dp #(
	parameter int MAX_SEGMENTS      = 16,
	parameter int HEADER_BYTES      = 32,
	parameter int POOL_HEADER_BYTES = 12,
	parameter int ADDR_BITS         = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         heap_size,
	input  logic [15:0]         request_bytes,
	input  bfsa_pkg::ctrl_cmd_t cmd,
	output bfsa_pkg::dp_stat_t  stat,
	output logic                done,
	output logic [1:0]          status
);

	import bfsa_pkg::*;

	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int AW   = ADDR_BITS;
	localparam int EW   = 2 * AW + 1;
	localparam int CMPW = ((AW > 16) ? AW : 16) + 1;
	localparam int OVERHEAD = POOL_HEADER_BYTES + HEADER_BYTES;

	logic [15:0]   heap_size_q;
	logic          fresh_q;
	logic [CW-1:0] count_q;
	logic [15:0]   req_q;
	logic [IW-1:0] scan_idx_q;
	logic [IW-1:0] rd_idx_s1;
	logic          eval_s1;
	logic          rd_fresh_s1;
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [AW-1:0] best_len_q;
	logic [AW-1:0] best_start_q;
	logic [IW-1:0] sh_ptr_q;
	logic          sh_wv_s1;
	logic [IW-1:0] sh_waddr_s1;
	logic          done_q;
	status_t       status_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [15:0]     init_len16;
	logic [AW-1:0]   init_len;
	logic [EW-1:0]   ent;
	logic            ent_busy;
	logic [AW-1:0]   ent_start;
	logic [AW-1:0]   ent_len;
	logic            ent_take;
	logic [CMPW-1:0] leftover;
	logic            split_ok;
	logic [AW-1:0]   new_start;
	logic [AW-1:0]   new_len;
	status_t         status_d;

	bfsa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entry 0 reads as the initial free segment until it is first written.
	assign init_len16 = (heap_size_q > 16'(OVERHEAD)) ? (heap_size_q - 16'(OVERHEAD)) : 16'd0;
	assign init_len   = AW'(init_len16);
	assign ent        = rd_fresh_s1 ? {1'b0, AW'(POOL_HEADER_BYTES), init_len} : ram_rdata;
	assign ent_busy   = ent[EW-1];
	assign ent_start  = ent[2*AW-1:AW];
	assign ent_len    = ent[AW-1:0];

	assign ent_take = eval_s1 && !ent_busy && (CMPW'(ent_len) >= CMPW'(req_q))
		&& (!found_q || (ent_len < best_len_q));

	assign leftover  = CMPW'(best_len_q) - CMPW'(req_q);
	assign split_ok  = found_q && (leftover >= CMPW'(HEADER_BYTES + 1))
		&& (count_q < CW'(MAX_SEGMENTS));
	assign new_start = best_start_q + AW'(HEADER_BYTES) + AW'(req_q);
	assign new_len   = AW'(leftover - CMPW'(HEADER_BYTES));

	assign ram_re    = cmd.scan_rd || cmd.shift_rd;
	assign ram_raddr = cmd.scan_rd ? scan_idx_q : sh_ptr_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = ram_rdata;
		if (cmd.commit_best) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = {1'b1, best_start_q, split_ok ? AW'(req_q) : best_len_q};
		end else if (sh_wv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = sh_waddr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.insert) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q + IW'(1);
			ram_wdata = {1'b0, new_start, new_len};
		end
	end

	assign status_d = cmd.insert ? ST_SPLIT : (found_q ? ST_WHOLE : ST_NOFIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= HEAP_SIZE_RESET;
			fresh_q     <= 1'b1;
			count_q     <= CW'(1);
			found_q     <= 1'b0;
			eval_s1     <= 1'b0;
			sh_wv_s1    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			eval_s1  <= cmd.scan_rd;
			sh_wv_s1 <= cmd.shift_rd;
			done_q   <= cmd.emit;
			if (cfg_we) begin
				heap_size_q <= heap_size;
				fresh_q     <= 1'b1;
				count_q     <= CW'(1);
			end else begin
				if (ram_we && (ram_waddr == '0)) begin
					fresh_q <= 1'b0;
				end
				if (cmd.insert) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (ent_take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= request_bytes;
			scan_idx_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_idx_q <= scan_idx_q + IW'(1);
		end
		rd_idx_s1   <= scan_idx_q;
		rd_fresh_s1 <= cmd.scan_rd && (scan_idx_q == '0) && fresh_q;
		if (ent_take) begin
			best_idx_q   <= rd_idx_s1;
			best_len_q   <= ent_len;
			best_start_q <= ent_start;
		end
		if (cmd.commit_best) begin
			sh_ptr_q <= IW'(count_q - CW'(1));
		end else if (cmd.shift_rd) begin
			sh_ptr_q <= sh_ptr_q - IW'(1);
		end
		sh_waddr_s1 <= sh_ptr_q + IW'(1);
		if (cmd.emit) begin
			status_q <= status_d;
		end
	end

	assign stat.scan_last  = (CW'(scan_idx_q) + CW'(1)) == count_q;
	assign stat.found      = found_q;
	assign stat.split      = split_ok;
	assign stat.shift_more = sh_ptr_q > best_idx_q;

	assign done   = done_q;
	assign status = status_q;

	`BFSA_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, (count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)), "segment count out of range")
	`BFSA_ASSERT_IMPL(a_insert_legal, clk, arst_n, cmd.insert, split_ok && !sh_wv_s1, "insert without a valid split")
	`BFSA_ASSERT_IMPL(a_shift_above_best, clk, arst_n, cmd.shift_rd, sh_ptr_q > best_idx_q, "shift read at or below chosen entry")
	`BFSA_ASSERT_IMPL(a_commit_alone, clk, arst_n, cmd.commit_best, found_q && !sh_wv_s1 && !cmd.insert, "commit collides with another write")

endmodule

// ===== hdl/best_fit_segment_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit segment allocator
// Address-ordered segment table with best-fit allocation and split on grant.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start is high and busy is low; request_bytes
//   is sampled on that edge. Each request yields exactly one result beat:
//   done pulses for one cycle with status (0 split, 1 whole, 2 no fit). The
//   receiver cannot stall, so it must take the beat in that cycle.
//   Writing heap_size (cfg_we high) reinitializes the table to one free
//   segment; write only while busy is low and no result is pending.
//   Reset sets heap_size to 4096 and the table to that single free segment.
// Operation (n = segments in the table, b = index of the chosen segment):
//   The table is a single-port-read RAM, one entry read per cycle. The scan
//   reads all n entries, waits in S_SCAN_WAIT for the last entry and decides
//   in S_DECIDE. No fit or whole grant: S_DECIDE emits the result. Split:
//   the entries above b are moved up one at a time in S_SHIFT, then S_INSERT
//   writes the split-off free segment and emits the result. A new request
//   may be taken in the cycle done is high.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator #(
	parameter int MAX_SEGMENTS      = bfsa_pkg::MAX_SEGMENTS_DEF,
	parameter int HEADER_BYTES      = bfsa_pkg::HEADER_BYTES_DEF,
	parameter int POOL_HEADER_BYTES = bfsa_pkg::POOL_HEADER_BYTES_DEF,
	parameter int ADDR_BITS         = bfsa_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] heap_size,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] request_bytes,
	output logic        done,
	output logic [1:0]  status
);

	import bfsa_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bfsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	bfsa_dp #(
		.MAX_SEGMENTS      (MAX_SEGMENTS),
		.HEADER_BYTES      (HEADER_BYTES),
		.POOL_HEADER_BYTES (POOL_HEADER_BYTES),
		.ADDR_BITS         (ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.heap_size     (heap_size),
		.request_bytes (request_bytes),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.status        (status)
	);

endmodule
